@@ rtl/bsfe_pkg.sv @@
// shared types, constants and the crc function of the byte-stuffed frame encoder
package bsfe_pkg;

    localparam int          MaxBytes   = 8;
    localparam int          IdxW       = $clog2(MaxBytes);
    localparam int          CntW       = $clog2(MaxBytes + 1);
    localparam int          AddrW      = 4;

    localparam logic [7:0]  StartReset = 8'd1;
    localparam logic [7:0]  EndReset   = 8'd4;
    localparam logic [7:0]  EscReset   = 8'd27;

    localparam logic [15:0] CrcInit    = 16'hFFFF;
    localparam logic [15:0] CrcPoly    = 16'hA001;

    // register indexes, byte address is index * 4
    localparam logic [1:0]  RegStart   = 2'd0;
    localparam logic [1:0]  RegEnd     = 2'd1;
    localparam logic [1:0]  RegEsc     = 2'd2;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [CntW-1:0]          cnt;
        logic                     done;
    } t_burst;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } t_codes;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/bsfe_build.sv @@
// builds the line byte burst of one item and the next frame state
module bsfe_build
    import bsfe_pkg::*;
(
    input  logic [7:0]  i_payload_byte,
    input  logic        i_has_payload,
    input  logic        i_final_byte,
    input  logic        i_in_frame,
    input  logic [15:0] i_crc,
    input  t_codes      i_codes,
    output logic        o_active,
    output t_burst      o_burst,
    output logic        o_in_frame,
    output logic [15:0] o_crc
);

    logic [15:0]     crc_base;
    logic [15:0]     crc_new;
    logic [CntW-1:0] n;

    function automatic logic is_code(input logic [7:0] b, input t_codes c);
        return (b == c.start_code) || (b == c.end_code) || (b == c.escape_code);
    endfunction

    assign o_active = i_has_payload | i_final_byte;
    assign crc_base = i_in_frame ? i_crc : CrcInit;
    assign crc_new  = i_has_payload ? crc_fold(crc_base, i_payload_byte) : crc_base;

    always_comb begin
        o_burst.bytes = '0;
        o_burst.done  = i_final_byte;
        n             = '0;
        if (!i_in_frame) begin
            o_burst.bytes[n[IdxW-1:0]] = i_codes.start_code;
            n = n + 1'b1;
        end
        if (i_has_payload) begin
            if (is_code(i_payload_byte, i_codes)) begin
                o_burst.bytes[n[IdxW-1:0]] = i_codes.escape_code;
                n = n + 1'b1;
            end
            o_burst.bytes[n[IdxW-1:0]] = i_payload_byte;
            n = n + 1'b1;
        end
        if (i_final_byte) begin
            if (is_code(crc_new[15:8], i_codes)) begin
                o_burst.bytes[n[IdxW-1:0]] = i_codes.escape_code;
                n = n + 1'b1;
            end
            o_burst.bytes[n[IdxW-1:0]] = crc_new[15:8];
            n = n + 1'b1;
            if (is_code(crc_new[7:0], i_codes)) begin
                o_burst.bytes[n[IdxW-1:0]] = i_codes.escape_code;
                n = n + 1'b1;
            end
            o_burst.bytes[n[IdxW-1:0]] = crc_new[7:0];
            n = n + 1'b1;
            o_burst.bytes[n[IdxW-1:0]] = i_codes.end_code;
            n = n + 1'b1;
        end
        o_burst.cnt = n;
    end

    always_comb begin
        if (i_final_byte) begin
            o_in_frame = 1'b0;
            o_crc      = CrcInit;
        end else begin
            o_in_frame = 1'b1;
            o_crc      = crc_new;
        end
    end

endmodule

@@ rtl/bsfe_serial.sv @@
// burst register and byte serializer toward the line side
module bsfe_serial
    import bsfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_line_byte,
    output logic       o_run_last,
    output logic       o_frame_done
);

    logic            r_valid, n_valid;
    logic [IdxW-1:0] r_idx, n_idx;
    t_burst          r_burst, n_burst;
    logic            last;
    logic            fire;

    assign last         = ({1'b0, r_idx} == (r_burst.cnt - 1'b1));
    assign fire         = r_valid && !i_stall;
    assign o_free       = !r_valid || (fire && last);
    assign o_valid      = r_valid;
    assign o_line_byte  = r_burst.bytes[r_idx];
    assign o_run_last   = last;
    assign o_frame_done = last && r_burst.done;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_burst = r_burst;
        if (fire) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = '0;
            n_burst = i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_burst <= n_burst;
    end

endmodule

@@ rtl/byte_stuffed_frame_encoder_crc16_top.sv @@
// top level of the byte-stuffed frame encoder with crc-16/modbus
//
// input channel: i_valid / o_stall carry one payload byte with has_payload and
// final_byte; a transfer happens when i_valid is high and o_stall low.
// output channel: o_valid / i_stall carry one line byte per transfer, with
// run_last on the last byte caused by an item and frame_done on the end code.
// apb port: start, end and escape codes at byte addresses 0, 4 and 8,
// pready always high, write only while the block is idle.
// an item is held in the input register, then its whole burst of
// one to eight line bytes is built in one pass and loaded into the burst
// register once the serializer is free, which then offers its first byte.
// the serializer sends one byte per cycle while i_stall is low, and the
// input register holds the next item meanwhile. idle items are dropped
// without waiting for the serializer. reset empties both stages, closes
// any frame, sets the crc to 0xffff and the codes to 1, 4 and 27. a stall
// on the line side holds the current byte and fills the input register,
// then o_stall rises.
module byte_stuffed_frame_encoder_crc16_top
    import bsfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_payload_byte,
    input  logic             i_has_payload,
    input  logic             i_final_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_line_byte,
    output logic             o_run_last,
    output logic             o_frame_done,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_codes      r_codes;
    logic        r_ivalid;
    logic [7:0]  r_data;
    logic        r_has, r_fin;
    logic        r_in_frame;
    logic [15:0] r_crc;

    logic        active;
    t_burst      burst;
    logic        nxt_in_frame;
    logic [15:0] nxt_crc;
    logic        free;
    logic        move;
    logic        load;
    logic        in_fire;
    logic        wr;

    // config registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            RegStart: prdata[7:0] = r_codes.start_code;
            RegEnd:   prdata[7:0] = r_codes.end_code;
            RegEsc:   prdata[7:0] = r_codes.escape_code;
            default:  prdata      = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.start_code  <= StartReset;
            r_codes.end_code    <= EndReset;
            r_codes.escape_code <= EscReset;
        end else if (wr) begin
            case (paddr[3:2])
                RegStart: r_codes.start_code  <= pwdata[7:0];
                RegEnd:   r_codes.end_code    <= pwdata[7:0];
                RegEsc:   r_codes.escape_code <= pwdata[7:0];
                default:  r_codes             <= r_codes;
            endcase
        end
    end

    bsfe_build u_build (
        .i_payload_byte (r_data),
        .i_has_payload  (r_has),
        .i_final_byte   (r_fin),
        .i_in_frame     (r_in_frame),
        .i_crc          (r_crc),
        .i_codes        (r_codes),
        .o_active       (active),
        .o_burst        (burst),
        .o_in_frame     (nxt_in_frame),
        .o_crc          (nxt_crc)
    );

    // idle items leave without a burst
    assign move    = r_ivalid && (!active || free);
    assign load    = move && active;
    assign o_stall = r_ivalid && !move;
    assign in_fire = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivalid   <= 1'b0;
            r_in_frame <= 1'b0;
            r_crc      <= CrcInit;
        end else begin
            if (in_fire) begin
                r_ivalid <= 1'b1;
            end else if (move) begin
                r_ivalid <= 1'b0;
            end
            if (load) begin
                r_in_frame <= nxt_in_frame;
                r_crc      <= nxt_crc;
            end
        end
        if (in_fire) begin
            r_data <= i_payload_byte;
            r_has  <= i_has_payload;
            r_fin  <= i_final_byte;
        end
    end

    bsfe_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (burst),
        .o_free       (free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_line_byte  (o_line_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_run_last)
        else $error("end code not on last byte of burst");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> free)
        else $error("burst loaded over a byte still pending");

    a_burst_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (burst.cnt != '0) && (burst.cnt <= CntW'(MaxBytes)))
        else $error("burst length out of range");

    a_frame_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_fin |=> !r_in_frame && r_crc == CrcInit)
        else $error("frame state not cleared after final item");

endmodule
